>>> rtl/core/csd_pkg.sv
// ----------------------------------------------------------------------------
// Closed syncmer detector package
// Shared widths, reset values, queue item and result types, and the
// sequencer states of the window-minimum engine.
// ----------------------------------------------------------------------------
package csd_pkg;

	// Default depth of the hash history and of the minimum queue.
	localparam int MAX_SPAN_DEF = 128;

	// Fixed field widths.
	localparam int HASH_W     = 32;
	localparam int CNT_W      = 32;
	localparam int SPAN_CFG_W = 8;

	// Window span after reset.
	localparam int SPAN_RESET = 70;

	// Saturation value of the syncmer count.
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// One request on its way from the front end to the engine.
	typedef struct packed {
		logic [HASH_W-1:0] hash;
		logic              last;
		logic              respan;
	} item_t;

	// One result leaving the engine.
	typedef struct packed {
		logic [CNT_W-1:0] total;
		logic             sync;
		logic             full;
		logic             last;
	} result_t;

	// Engine sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RB_RD,
		ST_RB_WAIT,
		ST_EXP,
		ST_EXP_WAIT,
		ST_PUSH,
		ST_PUSH_WAIT,
		ST_FIN
	} back_state_t;

endpackage

>>> rtl/core/csd_front.sv
// ----------------------------------------------------------------------------
// Closed syncmer detector front end
// Holds the window span register, accepts hash requests and tags the first
// request after a span change so that the engine rebuilds its queue.
// ----------------------------------------------------------------------------
module csd_front #(
	parameter int MAX_SPAN = csd_pkg::MAX_SPAN_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic [csd_pkg::SPAN_CFG_W-1:0]    cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [csd_pkg::HASH_W-1:0]        in_hash,
	input  logic                              in_last,
	output logic                              q_push,
	output csd_pkg::item_t                    q_item,
	input  logic                              q_full,
	output logic [$clog2(MAX_SPAN+1)-1:0]     span
);
	import csd_pkg::*;

	localparam int SW        = $clog2(MAX_SPAN + 1);
	localparam int CW        = (SW > SPAN_CFG_W) ? SW : SPAN_CFG_W;
	localparam int SPAN_INIT = (SPAN_RESET > MAX_SPAN) ? MAX_SPAN : SPAN_RESET;

	logic [CW-1:0] wr_ext;
	logic [SW-1:0] span_d;
	logic [SW-1:0] span_q;
	logic          respan_q;

	// Clamp the written span into the supported range; zero acts as one.
	assign wr_ext = CW'(cfg_wdata);

	always_comb begin
		if (wr_ext == '0) begin
			span_d = SW'(1);
		end else if (wr_ext > CW'(MAX_SPAN)) begin
			span_d = SW'(MAX_SPAN);
		end else begin
			span_d = SW'(wr_ext);
		end
	end

	// Span register and the pending-rebuild mark for the next request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_q   <= SW'(SPAN_INIT);
			respan_q <= 1'b0;
		end else if (cfg_wen) begin
			span_q   <= span_d;
			respan_q <= 1'b1;
		end else if (q_push) begin
			respan_q <= 1'b0;
		end
	end

	// Requests go straight into the queue while it has room.
	assign in_ready = !q_full;
	assign q_push   = in_valid && in_ready;
	assign span     = span_q;

	always_comb begin
		q_item        = '0;
		q_item.hash   = in_hash;
		q_item.last   = in_last;
		q_item.respan = respan_q;
	end

endmodule

>>> rtl/core/csd_fifo.sv
// ----------------------------------------------------------------------------
// Closed syncmer detector request queue
// Two-entry queue that decouples the front end from the engine.
// ----------------------------------------------------------------------------
module csd_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  csd_pkg::item_t  item_in,
	output logic            full,
	input  logic            pop,
	output logic            valid,
	output csd_pkg::item_t  item_out
);
	import csd_pkg::*;

	localparam int DEPTH = 2;

	item_t       slot_q [DEPTH];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;

	assign full     = (cnt_q == 2'(DEPTH));
	assign valid    = (cnt_q != 2'd0);
	assign item_out = slot_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= item_in;
		end
	end

endmodule

>>> rtl/core/csd_back.sv
// ----------------------------------------------------------------------------
// Closed syncmer detector engine
// Keeps the hash history and a monotonic minimum queue, decides per request
// whether the closed window is a syncmer, and holds the result register.
// ----------------------------------------------------------------------------
module csd_back #(
	parameter int MAX_SPAN = csd_pkg::MAX_SPAN_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_valid,
	input  csd_pkg::item_t                    q_item,
	output logic                              q_pop,
	input  logic [$clog2(MAX_SPAN+1)-1:0]     span,
	output logic                              res_valid,
	input  logic                              res_ready,
	output csd_pkg::result_t                  res
);
	import csd_pkg::*;

	localparam int AW = $clog2(MAX_SPAN);
	localparam int PW = AW + 1;
	localparam int SW = $clog2(MAX_SPAN + 1);

	back_state_t state_q;
	back_state_t state_d;

	// Request being worked on.
	logic [HASH_W-1:0] h_q;
	logic              last_q;

	// Rebuild and push operands.
	logic [SW-1:0]     rb_cnt_q;
	logic [HASH_W-1:0] push_val_q;
	logic [PW-1:0]     push_pos_q;
	logic              in_rb_q;

	// Minimum queue pointers and cached end entries.
	logic [AW-1:0]     head_q;
	logic [AW-1:0]     tail_q;
	logic [SW-1:0]     dq_cnt_q;
	logic [HASH_W-1:0] front_val_q;
	logic [PW-1:0]     front_pos_q;
	logic [HASH_W-1:0] back_val_q;

	// Sequence state.
	logic [PW-1:0]     pos_q;
	logic [AW-1:0]     wp_q;
	logic [SW-1:0]     fill_q;
	logic [CNT_W-1:0]  total_q;

	// Memories and their registered read data.
	logic [HASH_W-1:0] hist_mem   [MAX_SPAN];
	logic [HASH_W-1:0] dq_val_mem [MAX_SPAN];
	logic [PW-1:0]     dq_pos_mem [MAX_SPAN];
	logic [HASH_W-1:0] hist_rd_q;
	logic [HASH_W-1:0] dq_rd_val_q;
	logic [PW-1:0]     dq_rd_pos_q;

	// Result register.
	logic              out_valid_q;
	result_t           out_q;

	// Combinational helpers.
	logic [PW-1:0]     age;
	logic              expire;
	logic              pop_back;
	logic [AW-1:0]     head_nx;
	logic [AW-1:0]     tail_nx;
	logic [AW-1:0]     tail_dec;
	logic [AW-1:0]     tail_dec2;
	logic [SW:0]       rb_sum;
	logic [AW-1:0]     hist_raddr;
	logic [AW-1:0]     dq_raddr;
	logic [SW-1:0]     rb_init;
	logic [SW-1:0]     fill_new;
	logic              full;
	logic              sync;
	logic [CNT_W-1:0]  total_new;
	logic              out_free;

	// Sequencer strobes.
	logic take_item;
	logic rb_step;
	logic rb_load;
	logic exp_pop;
	logic front_load;
	logic push_item;
	logic push_pop;
	logic push_wr;
	logic back_load;
	logic commit;
	logic hist_re;
	logic dq_re;

	function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] a);
		ring_inc = (a == AW'(MAX_SPAN - 1)) ? '0 : a + AW'(1);
	endfunction

	function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] a);
		ring_dec = (a == '0) ? AW'(MAX_SPAN - 1) : a - AW'(1);
	endfunction

	// Pointer arithmetic on the circular stores.
	assign head_nx   = ring_inc(head_q);
	assign tail_nx   = ring_inc(tail_q);
	assign tail_dec  = ring_dec(tail_q);
	assign tail_dec2 = ring_dec(tail_dec);

	// History address of the entry rb_cnt_q places before the current one.
	assign rb_sum     = (SW+1)'(wp_q) + (SW+1)'(MAX_SPAN) - (SW+1)'(rb_cnt_q);
	assign hist_raddr = (rb_sum >= (SW+1)'(MAX_SPAN)) ?
		AW'(rb_sum - (SW+1)'(MAX_SPAN)) : AW'(rb_sum);
	assign dq_raddr   = (state_q == ST_EXP) ? head_nx : tail_dec2;

	// Rebuild length: the earlier hashes that fall into the next window.
	assign rb_init = (fill_q < span) ? fill_q : span - SW'(1);

	// Queue tests.
	assign age      = pos_q - front_pos_q;
	assign expire   = (dq_cnt_q != '0) && (age >= PW'(span));
	assign pop_back = (dq_cnt_q != '0) && (back_val_q > push_val_q);

	// Window decision: the minimum is either the oldest entry or the newest.
	assign fill_new  = (fill_q == SW'(MAX_SPAN)) ? fill_q : fill_q + SW'(1);
	assign full      = (fill_new >= span);
	assign sync      = full &&
		((age == PW'(span) - PW'(1)) || (front_val_q == h_q));
	assign total_new = (sync && (total_q != CNT_MAX)) ? total_q + CNT_W'(1) : total_q;
	assign out_free  = !out_valid_q || res_ready;

	// Next state and strobes.
	always_comb begin
		state_d    = state_q;
		take_item  = 1'b0;
		rb_step    = 1'b0;
		rb_load    = 1'b0;
		exp_pop    = 1'b0;
		front_load = 1'b0;
		push_item  = 1'b0;
		push_pop   = 1'b0;
		push_wr    = 1'b0;
		back_load  = 1'b0;
		commit     = 1'b0;
		hist_re    = 1'b0;
		dq_re      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					take_item = 1'b1;
					state_d   = q_item.respan ? ST_RB_RD : ST_EXP;
				end
			end
			ST_RB_RD: begin
				if (rb_cnt_q == '0) begin
					state_d = ST_EXP;
				end else begin
					rb_step = 1'b1;
					hist_re = 1'b1;
					state_d = ST_RB_WAIT;
				end
			end
			ST_RB_WAIT: begin
				rb_load = 1'b1;
				state_d = ST_PUSH;
			end
			ST_EXP: begin
				if (expire) begin
					exp_pop = 1'b1;
					if (dq_cnt_q > SW'(1)) begin
						dq_re   = 1'b1;
						state_d = ST_EXP_WAIT;
					end
				end else begin
					push_item = 1'b1;
					state_d   = ST_PUSH;
				end
			end
			ST_EXP_WAIT: begin
				front_load = 1'b1;
				state_d    = ST_EXP;
			end
			ST_PUSH: begin
				if (pop_back) begin
					push_pop = 1'b1;
					if (dq_cnt_q > SW'(1)) begin
						dq_re   = 1'b1;
						state_d = ST_PUSH_WAIT;
					end
				end else begin
					push_wr = 1'b1;
					state_d = in_rb_q ? ST_RB_RD : ST_FIN;
				end
			end
			ST_PUSH_WAIT: begin
				back_load = 1'b1;
				state_d   = ST_PUSH;
			end
			ST_FIN: begin
				if (out_free) begin
					commit  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign q_pop = take_item;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Queue pointers, sequence state and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			dq_cnt_q    <= '0;
			pos_q       <= '0;
			wp_q        <= '0;
			fill_q      <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take_item && q_item.respan) begin
				head_q   <= '0;
				tail_q   <= '0;
				dq_cnt_q <= '0;
			end
			if (exp_pop) begin
				head_q   <= head_nx;
				dq_cnt_q <= dq_cnt_q - SW'(1);
			end
			if (push_pop) begin
				tail_q   <= tail_dec;
				dq_cnt_q <= dq_cnt_q - SW'(1);
			end
			if (push_wr) begin
				tail_q   <= tail_nx;
				dq_cnt_q <= dq_cnt_q + SW'(1);
			end
			if (commit) begin
				pos_q <= pos_q + PW'(1);
				wp_q  <= ring_inc(wp_q);
				if (last_q) begin
					fill_q   <= '0;
					total_q  <= '0;
					head_q   <= '0;
					tail_q   <= '0;
					dq_cnt_q <= '0;
				end else begin
					fill_q  <= fill_new;
					total_q <= total_new;
				end
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (take_item) begin
			h_q    <= q_item.hash;
			last_q <= q_item.last;
		end
		if (take_item && q_item.respan) begin
			rb_cnt_q <= rb_init;
		end
		if (rb_step) begin
			push_pos_q <= pos_q - PW'(rb_cnt_q);
			rb_cnt_q   <= rb_cnt_q - SW'(1);
		end
		if (rb_load) begin
			push_val_q <= hist_rd_q;
			in_rb_q    <= 1'b1;
		end
		if (push_item) begin
			push_val_q <= h_q;
			push_pos_q <= pos_q;
			in_rb_q    <= 1'b0;
		end
		if (front_load) begin
			front_val_q <= dq_rd_val_q;
			front_pos_q <= dq_rd_pos_q;
		end
		if (back_load) begin
			back_val_q <= dq_rd_val_q;
		end
		if (push_wr) begin
			back_val_q <= push_val_q;
			if (dq_cnt_q == '0) begin
				front_val_q <= push_val_q;
				front_pos_q <= push_pos_q;
			end
		end
		if (commit) begin
			out_q.total <= last_q ? total_new : total_new;
			out_q.sync  <= sync;
			out_q.full  <= full;
			out_q.last  <= last_q;
		end
	end

	// Hash history memory.
	always_ff @(posedge clk) begin
		if (commit) begin
			hist_mem[wp_q] <= h_q;
		end
		if (hist_re) begin
			hist_rd_q <= hist_mem[hist_raddr];
		end
	end

	// Minimum queue memory.
	always_ff @(posedge clk) begin
		if (push_wr) begin
			dq_val_mem[tail_q] <= push_val_q;
			dq_pos_mem[tail_q] <= push_pos_q;
		end
		if (dq_re) begin
			dq_rd_val_q <= dq_val_mem[dq_raddr];
			dq_rd_pos_q <= dq_pos_mem[dq_raddr];
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

	// The queue never holds more entries than the history depth.
	a_dq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dq_cnt_q <= SW'(MAX_SPAN))
		else $error("minimum queue overflow");

	// The fill level saturates at the history depth.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= SW'(MAX_SPAN))
		else $error("fill level out of range");

	// After the push the queue holds at least the newest hash.
	a_fin_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |-> (dq_cnt_q != '0))
		else $error("empty minimum queue at decision");

	// A syncmer is only reported for a complete window.
	a_sync_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.sync) |-> out_q.full)
		else $error("syncmer flagged on an incomplete window");

	// A result is only loaded when the result register is free.
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> out_free)
		else $error("result overwritten before it was taken");

endmodule

>>> rtl/core/closed_syncmer_detector_unit.sv
// ----------------------------------------------------------------------------
// Closed syncmer detector unit
// The engine works on one request at a time; each queue entry that leaves the
// window or is displaced by a smaller hash adds a pop step to its request, and
// every entry leaves the queue at most once.
// The first request after a span write first rebuilds the minimum queue from
// the history memory, reading and pushing each earlier hash inside the new window.
// Reset clears control state at once; there is no clearing pass.
// ----------------------------------------------------------------------------
module closed_syncmer_detector_unit #(
	parameter int MAX_SPAN = csd_pkg::MAX_SPAN_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic [csd_pkg::SPAN_CFG_W-1:0]    cfg_wdata,      // window_span
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [csd_pkg::HASH_W-1:0]        s_axis_tdata,   // hash_value
	input  logic                              s_axis_tlast,   // last_in_sequence
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [csd_pkg::CNT_W-1:0]         m_axis_tdata,   // syncmer_total
	output logic [1:0]                        m_axis_tuser,   // is_syncmer, window_full
	output logic                              m_axis_tlast    // sequence_done
);
	import csd_pkg::*;

	localparam int SW = $clog2(MAX_SPAN + 1);

	logic          q_push;
	logic          q_full;
	logic          q_pop;
	logic          q_valid;
	item_t         q_in;
	item_t         q_out;
	logic [SW-1:0] span;
	result_t       res;

	// Front end: span register and request intake.
	csd_front #(
		.MAX_SPAN(MAX_SPAN)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_hash  (s_axis_tdata),
		.in_last  (s_axis_tlast),
		.q_push   (q_push),
		.q_item   (q_in),
		.q_full   (q_full),
		.span     (span)
	);

	// Request queue between the front end and the engine.
	csd_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.item_in (q_in),
		.full    (q_full),
		.pop     (q_pop),
		.valid   (q_valid),
		.item_out(q_out)
	);

	// Window-minimum engine and result register.
	csd_back #(
		.MAX_SPAN(MAX_SPAN)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_item   (q_out),
		.q_pop    (q_pop),
		.span     (span),
		.res_valid(m_axis_tvalid),
		.res_ready(m_axis_tready),
		.res      (res)
	);

	// Result fields onto the output stream.
	assign m_axis_tdata = res.total;
	assign m_axis_tuser = {res.sync, res.full};
	assign m_axis_tlast = res.last;

endmodule
